>>> rtl/modexp_pkg.sv
// Package for the modular exponentiation block: widths, microcode types and the control program.
package modexp_pkg;

    localparam int MOD_W            = 31;
    localparam int BASE_W           = 32;
    localparam int EXP_BITS_DEFAULT = 63;
    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

    // A multiply takes the multiplier's top bit in a load step and its other bits as the counter runs to CNT_LAST.
    localparam int CNT_W = $clog2(MOD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_W - 1);

    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_WAIT = 3'd0;
    localparam logic [STEP_W-1:0] STEP_BASE = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MULT = 3'd2;
    localparam logic [STEP_W-1:0] STEP_SQR  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_EMIT = 3'd4;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_MUL,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        SA_ONE,
        SA_ACC,
        SA_SQR
    } sel_a_t;

    typedef enum logic [1:0] {
        SB_BASE,
        SB_ACC,
        SB_SQR
    } sel_b_t;

    typedef enum logic {
        DST_SQR,
        DST_ACC
    } dest_t;

    typedef enum logic [1:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_EXP_ZERO,
        JC_EXP_HI_ZERO
    } jcond_t;

    typedef struct packed {
        op_t               op;
        sel_a_t            sel_a;
        sel_b_t            sel_b;
        dest_t             dest;
        logic              only_if_lsb;
        logic              shift_exp;
        jcond_t            jcond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // The control program. A step that finishes goes to its target when the jump
    // condition holds and to the following step otherwise.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        w = '{op: OP_WAIT, sel_a: SA_ONE, sel_b: SB_BASE, dest: DST_SQR,
              only_if_lsb: 1'b0, shift_exp: 1'b0, jcond: JC_NEVER, target: STEP_WAIT};
        unique case (addr)
            STEP_WAIT: begin
                w.op = OP_WAIT;
            end
            STEP_BASE: begin
                // Reduce the base: 1 * base mod m.
                w.op     = OP_MUL;
                w.sel_a  = SA_ONE;
                w.sel_b  = SB_BASE;
                w.dest   = DST_SQR;
                w.jcond  = JC_EXP_ZERO;
                w.target = STEP_EMIT;
            end
            STEP_MULT: begin
                w.op          = OP_MUL;
                w.sel_a       = SA_ACC;
                w.sel_b       = SB_SQR;
                w.dest        = DST_ACC;
                w.only_if_lsb = 1'b1;
                w.jcond       = JC_EXP_HI_ZERO;
                w.target      = STEP_EMIT;
            end
            STEP_SQR: begin
                w.op        = OP_MUL;
                w.sel_a     = SA_SQR;
                w.sel_b     = SB_SQR;
                w.dest      = DST_SQR;
                w.shift_exp = 1'b1;
                w.jcond     = JC_ALWAYS;
                w.target    = STEP_MULT;
            end
            STEP_EMIT: begin
                w.op     = OP_EMIT;
                w.jcond  = JC_ALWAYS;
                w.target = STEP_WAIT;
            end
            default: begin
                w.op     = OP_WAIT;
                w.jcond  = JC_ALWAYS;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/modular_exponentiation.sv
// Modular exponentiation top level: microcoded square-and-multiply over a bit-serial modular multiplier.
// The steps are the wait step, a multiply that reduces the base, then per exponent bit up to the highest
// set one a multiply (skipped when the bit is clear) and, below the highest set bit, a squaring;
// then the emit step. One word is in flight at a time; the emit step holds while the output
// register still holds an untaken word. Reset (aresetn low, synchronous) empties the output register,
// returns the sequencer to its wait step and sets the modulus to 1000000007.
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [MOD_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BASE_W-1:0]   s_base_value,
    input  logic [EXP_BITS-1:0] s_exponent,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [MOD_W-1:0]    m_power_result
);

    // Configuration. A written zero is stored as one, which is how every
    // reduction treats a zero modulus.
    logic [MOD_W-1:0] modulus_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MOD_RESET;
        end else if (cfg_wr_en) begin
            modulus_reg <= (cfg_wr_data == '0) ? MOD_W'(1) : cfg_wr_data;
        end
    end

    // Sequencer state and datapath registers.
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MOD_W-1:0]    r_reg, r_next;
    logic [BASE_W-1:0]   mb_reg, mb_next;
    logic [MOD_W-1:0]    acc_reg, acc_next;
    logic [MOD_W-1:0]    sqr_reg, sqr_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic                out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]    out_data_reg, out_data_next;

    ucode_t cw;
    logic   in_accept;
    logic   mul_skip;
    logic   mul_last;
    logic   step_done;
    logic   jump_taken;

    assign cw        = ucode_rom(step_reg);
    assign s_ready   = (cw.op == OP_WAIT);
    assign in_accept = s_valid && s_ready;

    // Operand selection for the shared multiplier. Operand A is added in on
    // each set multiplier bit; operand B is the multiplier, scanned from its top bit.
    logic [MOD_W-1:0]  a_val;
    logic [BASE_W-1:0] b_val;

    always_comb begin
        unique case (cw.sel_a)
            SA_ONE:  a_val = MOD_W'(1);
            SA_ACC:  a_val = acc_reg;
            SA_SQR:  a_val = sqr_reg;
            default: a_val = MOD_W'(1);
        endcase
        unique case (cw.sel_b)
            SB_BASE: b_val = base_reg;
            SB_ACC:  b_val = {1'b0, acc_reg};
            SB_SQR:  b_val = {1'b0, sqr_reg};
            default: b_val = base_reg;
        endcase
    end

    // One multiplier step: r = (2r + bit*a) mod m. With r and a below m the
    // sum is below 3m, so it is fixed up by subtracting m or 2m at most.
    logic                bit_in;
    logic [MOD_W-1:0]    r_in;
    logic [MOD_W+1:0]    t_sum;
    logic [MOD_W+1:0]    m_twice;
    logic [MOD_W+2:0]    t_m1;
    logic [MOD_W+2:0]    t_m2;
    logic [MOD_W-1:0]    r_step;

    always_comb begin
        bit_in  = busy_reg ? mb_reg[BASE_W-1] : b_val[BASE_W-1];
        r_in    = busy_reg ? r_reg : '0;
        t_sum   = {1'b0, r_in, 1'b0} + (bit_in ? {2'b00, a_val} : '0);
        m_twice = {1'b0, modulus_reg, 1'b0};
        t_m1    = {1'b0, t_sum} - {3'b000, modulus_reg};
        t_m2    = {1'b0, t_sum} - {1'b0, m_twice};
        if (!t_m2[MOD_W+2]) begin
            r_step = t_m2[MOD_W-1:0];
        end else if (!t_m1[MOD_W+2]) begin
            r_step = t_m1[MOD_W-1:0];
        end else begin
            r_step = t_sum[MOD_W-1:0];
        end
    end

    // Step completion and the conditional jump.
    always_comb begin
        mul_skip = cw.only_if_lsb && !exp_reg[0];
        mul_last = busy_reg && (cnt_reg == CNT_LAST);
        unique case (cw.op)
            OP_WAIT: step_done = s_valid;
            OP_MUL:  step_done = mul_skip || mul_last;
            OP_EMIT: step_done = !out_valid_reg || m_ready;
            default: step_done = 1'b1;
        endcase
        unique case (cw.jcond)
            JC_NEVER:       jump_taken = 1'b0;
            JC_ALWAYS:      jump_taken = 1'b1;
            JC_EXP_ZERO:    jump_taken = (exp_reg == '0);
            JC_EXP_HI_ZERO: jump_taken = ((exp_reg >> 1) == '0);
            default:        jump_taken = 1'b0;
        endcase
    end

    // Next-state logic for the sequencer and datapath.
    always_comb begin
        step_next      = step_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        mb_next        = mb_reg;
        acc_next       = acc_reg;
        sqr_next       = sqr_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (in_accept) begin
            base_next = s_base_value;
            exp_next  = s_exponent;
            acc_next  = MOD_W'(1);
        end

        if (cw.op == OP_MUL && !mul_skip) begin
            // The load cycle already handles the multiplier's top bit.
            r_next   = r_step;
            mb_next  = busy_reg ? (mb_reg << 1) : (b_val << 1);
            cnt_next = busy_reg ? cnt_reg + CNT_W'(1) : '0;
            busy_next = !mul_last;
            if (mul_last) begin
                if (cw.dest == DST_ACC) begin
                    acc_next = r_step;
                end else begin
                    sqr_next = r_step;
                end
                if (cw.shift_exp) begin
                    exp_next = exp_reg >> 1;
                end
            end
        end

        if (cw.op == OP_EMIT && step_done) begin
            out_valid_next = 1'b1;
            out_data_next  = acc_reg;
        end

        if (step_done) begin
            step_next = jump_taken ? cw.target : step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_WAIT;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        r_reg        <= r_next;
        mb_reg       <= mb_next;
        acc_reg      <= acc_next;
        sqr_reg      <= sqr_next;
        base_reg     <= base_next;
        exp_reg      <= exp_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_power_result = out_data_reg;

    // The multiplier only runs under a multiply step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cw.op == OP_MUL))
        else $error("multiplier busy outside a multiply step");

    // An accepted word always starts with the base reduction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (step_reg == STEP_BASE))
        else $error("accepted word did not start base reduction");

    // A result only appears from the emit step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(step_reg) == STEP_EMIT))
        else $error("result appeared outside the emit step");

endmodule

>>> tb/sv/power_checker.sv
// Checker for the modular exponentiation block: tracks the modulus, predicts each power and compares.
module power_checker
    import modexp_pkg::*;
#(
    parameter int EXP_W = EXP_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [MOD_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [BASE_W-1:0] s_base_value,
    input  logic [EXP_W-1:0]  s_exponent,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [MOD_W-1:0]  m_power_result,
    output int                mismatches,
    output int                pending
);

    logic [MOD_W-1:0] modulus_q;
    logic [MOD_W-1:0] expected_powers[$];
    int               error_count;

    // Right-to-left square-and-multiply; a modulus of zero acts as one.
    function automatic logic [MOD_W-1:0] modpow(input logic [BASE_W-1:0] base,
                                                input logic [EXP_W-1:0]  exponent,
                                                input logic [MOD_W-1:0]  modulus);
        logic [63:0] m;
        logic [63:0] sq;
        logic [63:0] acc;
        m   = (modulus == '0) ? 64'd1 : 64'(modulus);
        sq  = 64'(base) % m;
        acc = 64'd1;
        for (int i = 0; i < EXP_W; i++) begin
            if (exponent[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[MOD_W-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [MOD_W-1:0] want;
        if (!aresetn) begin
            modulus_q   = MOD_RESET;
            error_count = 0;
            expected_powers.delete();
        end else begin
            if (cfg_wr_en) begin
                modulus_q = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                expected_powers = {expected_powers,
                                   modpow(s_base_value, s_exponent, modulus_q)};
            end
            if (m_valid && m_ready) begin
                if (expected_powers.size() == 0) begin
                    $error("power_result: unexpected word %0d", m_power_result);
                    error_count++;
                end else begin
                    want = expected_powers.pop_front();
                    if (m_power_result !== want) begin
                        $error("power_result: expected %0d, actual %0d", want, m_power_result);
                        error_count++;
                    end
                end
            end
        end
        mismatches <= error_count;
        pending    <= expected_powers.size();
    end

endmodule

>>> tb/sv/modular_exponentiation_test.sv
// Testbench top for the modular exponentiation block: stimulus, idling, modulus phases and verdict.
module modular_exponentiation_test;
    import modexp_pkg::*;

    localparam int EXP_W = EXP_BITS_DEFAULT;
    localparam logic [EXP_W-1:0] EXP_MAX = '1;
    localparam logic [EXP_W-1:0] EXP_TOP = EXP_W'(1) << (EXP_W - 1);
    localparam logic [MOD_W-1:0] MOD_MAX = '1;
    // The run has some 140 words.
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 4200;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [MOD_W-1:0]  cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic [BASE_W-1:0] s_base_value;
    logic [EXP_W-1:0]  s_exponent;
    logic              m_valid;
    logic              m_ready;
    logic [MOD_W-1:0]  m_power_result;

    int               mismatches;
    int               pending;
    int               cycle_count = 0;
    // When set, both sides run without idling, so back-to-back traffic is covered too.
    bit               steady;
    logic [MOD_W-1:0] modulus_now;

    modular_exponentiation #(
        .EXP_BITS(EXP_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_value  (s_base_value),
        .s_exponent    (s_exponent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_result(m_power_result)
    );

    power_checker #(
        .EXP_W(EXP_W)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_value  (s_base_value),
        .s_exponent    (s_exponent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_power_result(m_power_result),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always #6 aclk = ~aclk;

    // A hung block would otherwise stall the run forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Number of idle cycles before the next word on either side.
    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    // Offers one word and holds it until the block takes it. The valid is only
    // lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input logic [BASE_W-1:0] base, input logic [EXP_W-1:0] exponent);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_base_value <= base;
        s_exponent   <= exponent;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(0, 15) == 0) begin
            steady = !steady;
        end
    endtask

    // Stops offering words and waits until every expected power has come back.
    // The extra edge lets the checker count the word taken at the last handshake.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // The block is idle whenever this is called.
    task automatic write_modulus(input logic [MOD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        modulus_now = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Bases lean toward zero, all ones and multiples of the modulus, where the
    // reduction before the first squaring matters most.
    function automatic logic [BASE_W-1:0] pick_base();
        logic [63:0] scaled;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: begin
                scaled = 64'(modulus_now) * $urandom_range(0, 2);
                return scaled[BASE_W-1:0];
            end
            3: return BASE_W'(modulus_now) - 1;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Latency grows with the highest set exponent bit, so widths are drawn
    // uniformly and only a few words carry the full exponent.
    function automatic logic [EXP_W-1:0] pick_exponent();
        logic [63:0] raw;
        int          width;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom_range(1, 8);
            2: return EXP_MAX;
            3: return raw[EXP_W-1:0];
            default: begin
                width = $urandom_range(1, EXP_W);
                return raw[EXP_W-1:0] & ((EXP_W'(1) << width) - 1);
            end
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_word(pick_base(), pick_exponent());
    endtask

    // Result side: per word a random stall, sometimes begun only once the
    // word is already waiting, so stalls land on both sides of m_valid.
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                if ($urandom_range(0, 1) == 0) begin
                    do @(posedge aclk); while (!m_valid);
                end
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_base_value = '0;
        s_exponent   = '0;
        steady       = 1'b0;
        modulus_now  = MOD_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Modulus left at its reset value: zero exponents, the widest operands,
        // a lone top exponent bit and bases equal to or just under the modulus.
        send_word('0, '0);
        send_word('0, 1);
        send_word('1, '0);
        send_word('1, 1);
        send_word('1, EXP_MAX);
        send_word(1, EXP_MAX);
        send_word(2, EXP_TOP);
        send_word(BASE_W'(MOD_RESET), 5);
        send_word(BASE_W'(MOD_RESET) - 1, 2);
        send_word(3, EXP_W'({(EXP_W+1)/2{2'b01}}));
        send_random(20);
        drain();

        // Largest modulus; a base equal to it must come out as zero.
        write_modulus(MOD_MAX);
        send_word('1, EXP_MAX);
        send_word(BASE_W'(MOD_MAX), 3);
        send_word(BASE_W'(MOD_MAX) - 1, EXP_MAX);
        send_random(20);
        drain();

        // Modulus one: a zero exponent still gives one, anything else zero.
        write_modulus(MOD_W'(1));
        send_word(5, '0);
        send_word(5, 1);
        send_word('1, EXP_MAX);
        send_random(10);
        drain();

        // A modulus of zero behaves as a modulus of one.
        write_modulus('0);
        send_word(7, '0);
        send_word(7, 3);
        send_word('0, '0);
        send_random(10);
        drain();

        write_modulus(MOD_W'($urandom_range(2, 32'h7FFF_FFFF)));
        send_random(30);
        drain();

        // A tiny modulus makes the running values wrap on almost every step.
        write_modulus(MOD_W'($urandom_range(2, 64)));
        send_random(20);
        drain();

        write_modulus(MOD_RESET);
        send_random(10);
        drain();

        // Give a stray word time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
